[design/crm_pkg.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Shared widths, mode and command codes, decision constants and the job record
// passed from the step engine to the pixel emitter.
// ----------------------------------------------------------------------------
package crm_pkg;

   localparam int COORD_BITS     = 12;
   localparam int RADIUS_BITS    = 11;
   localparam int PIX_BITS       = COORD_BITS + 2;
   localparam int SX_BITS        = RADIUS_BITS + 2;
   localparam int SY_BITS        = RADIUS_BITS + 1;
   localparam int DEC_BITS       = RADIUS_BITS + 5;
   localparam int SQ_BITS        = 2 * RADIUS_BITS;
   localparam int MODE_BITS      = 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int SLOT_BITS      = 3;

   localparam logic [MODE_BITS-1:0] MODE_COLUMN    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_BRESENHAM = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MIDPOINT  = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_RESET     = MODE_BRESENHAM;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [DEC_BITS-1:0] BRES_INIT       = DEC_BITS'(3);
   localparam logic [DEC_BITS-1:0] BRES_INC_AXIAL  = DEC_BITS'(6);
   localparam logic [DEC_BITS-1:0] BRES_INC_DIAG   = DEC_BITS'(10);
   localparam logic [DEC_BITS-1:0] MID_INIT        = DEC_BITS'(1);
   localparam logic [DEC_BITS-1:0] MID_INC         = DEC_BITS'(1);

   localparam logic [SLOT_BITS-1:0] LAST_OCTANT_SLOT = SLOT_BITS'(7);
   localparam logic [SLOT_BITS-1:0] LAST_COLUMN_SLOT = SLOT_BITS'(1);

   typedef enum logic {
      JOB_OCTANT,
      JOB_COLUMN
   } job_kind_type;

   typedef struct packed {
      job_kind_type        kind;
      logic [PIX_BITS-1:0] x_base;
      logic [PIX_BITS-1:0] y_base;
      logic [PIX_BITS-1:0] a;
      logic [PIX_BITS-1:0] b;
      logic                done;
   } job_type;

endpackage

[design/crm_req_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying start and step commands.
// ----------------------------------------------------------------------------
interface crm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [crm_pkg::COORD_BITS-1:0]   center_x;
   logic [crm_pkg::COORD_BITS-1:0]   center_y;
   logic [crm_pkg::RADIUS_BITS-1:0]  radius;

   modport source (output valid, command, center_x, center_y, radius, input ready);
   modport sink   (input valid, command, center_x, center_y, radius, output ready);
endinterface

[design/crm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying generated pixels and their step flags.
// ----------------------------------------------------------------------------
interface crm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [crm_pkg::PIX_BITS-1:0] pixel_x;
   logic signed [crm_pkg::PIX_BITS-1:0] pixel_y;
   logic                                last_of_step;
   logic                                curve_done;

   modport source (output valid, pixel_x, pixel_y, last_of_step, curve_done, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_of_step, curve_done, output ready);
endinterface

[design/crm_isqrt.sv]
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module crm_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [crm_pkg::SQ_BITS-1:0]     radicand,
   output logic                            busy,
   output logic [crm_pkg::RADIUS_BITS-1:0] root
);

   logic [crm_pkg::SQ_BITS-1:0] rem_ff;
   logic [crm_pkg::SQ_BITS-1:0] res_ff;
   logic [crm_pkg::SQ_BITS-1:0] bit_ff;
   logic                        busy_ff;
   logic [crm_pkg::SQ_BITS-1:0] trial;
   logic                        fits;

   always_comb begin
      trial = res_ff + bit_ff;
      fits  = rem_ff >= trial;
      busy  = busy_ff;
      root  = res_ff[crm_pkg::RADIUS_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         rem_ff  <= radicand;
         res_ff  <= '0;
         bit_ff  <= crm_pkg::SQ_BITS'(1) << (crm_pkg::SQ_BITS - 2);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_ff <= 1'b0;
         end
      end
   end

endmodule

[design/crm_front.sv]
// ----------------------------------------------------------------------------
// Circle step engine
// Accepts commands, holds the circle state, runs one iteration of the selected
// scheme per step and queues a pixel job for the emitter.
// ----------------------------------------------------------------------------
module crm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [crm_pkg::MODE_BITS-1:0]   csr_write_data,
   crm_req_if.sink                         req,
   input  logic                            queue_full,
   output logic                            push,
   output crm_pkg::job_type                push_job
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_START,
      F_ROOT
   } state_type;

   state_type                          state_ff;
   logic [crm_pkg::MODE_BITS-1:0]      mode_ff;
   logic [crm_pkg::COORD_BITS-1:0]     cx_ff;
   logic [crm_pkg::COORD_BITS-1:0]     cy_ff;
   logic [crm_pkg::RADIUS_BITS-1:0]    r_ff;
   logic [crm_pkg::SX_BITS-1:0]        sx_ff;
   logic [crm_pkg::SY_BITS-1:0]        sy_ff;
   logic [crm_pkg::DEC_BITS-1:0]       dec_ff;
   logic                               first_ff;
   logic                               fin_ff;
   logic [crm_pkg::RADIUS_BITS-1:0]    off_ff;
   logic [crm_pkg::PIX_BITS-1:0]       col_ff;
   logic [crm_pkg::SQ_BITS-1:0]        rr_ff;
   logic [crm_pkg::SQ_BITS-1:0]        oo_ff;

   logic                               accept;
   logic                               stepping;
   logic [crm_pkg::DEC_BITS-1:0]       x_ext;
   logic [crm_pkg::DEC_BITS-1:0]       y_ext;
   logic                               dec_neg;
   logic [crm_pkg::DEC_BITS-1:0]       bres_x;
   logic [crm_pkg::DEC_BITS-1:0]       bres_y;
   logic [crm_pkg::DEC_BITS-1:0]       bres_d;
   logic                               bres_fin;
   logic [crm_pkg::DEC_BITS-1:0]       mid_x;
   logic [crm_pkg::DEC_BITS-1:0]       mid_y;
   logic [crm_pkg::DEC_BITS-1:0]       mid_d;
   logic                               mid_fin;
   logic [crm_pkg::SX_BITS-1:0]        two_r;
   logic                               col_over;
   logic [crm_pkg::SX_BITS-1:0]        col_next_x;
   logic                               col_fin;
   logic [crm_pkg::RADIUS_BITS-1:0]    col_off;
   logic [crm_pkg::PIX_BITS-1:0]       col_base;
   logic                               sq_start;
   logic                               sq_busy;
   logic [crm_pkg::RADIUS_BITS-1:0]    sq_root;
   logic [crm_pkg::PIX_BITS-1:0]       cx_pix;
   logic [crm_pkg::PIX_BITS-1:0]       cy_pix;

   crm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (rr_ff - oo_ff),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   always_comb begin
      req.ready = (state_ff == F_IDLE) && !queue_full;
      accept    = req.valid && req.ready;
      stepping  = accept && (req.command == crm_pkg::CMD_STEP) && !fin_ff;
      sq_start  = (state_ff == F_START);
      cx_pix    = crm_pkg::PIX_BITS'(cx_ff);
      cy_pix    = crm_pkg::PIX_BITS'(cy_ff);

      x_ext   = crm_pkg::DEC_BITS'(sx_ff);
      y_ext   = crm_pkg::DEC_BITS'(sy_ff);
      dec_neg = dec_ff[crm_pkg::DEC_BITS-1];

      bres_x = x_ext + crm_pkg::DEC_BITS'(1);
      if (dec_neg) begin
         bres_y = y_ext;
         bres_d = dec_ff + (x_ext << 2) + crm_pkg::BRES_INC_AXIAL;
      end else begin
         bres_y = y_ext - crm_pkg::DEC_BITS'(1);
         bres_d = dec_ff + ((x_ext - y_ext) << 2) + crm_pkg::BRES_INC_DIAG;
      end
      bres_fin = $signed(bres_x) > $signed(bres_y);

      if (first_ff) begin
         mid_x = x_ext;
         mid_y = y_ext;
         mid_d = dec_ff;
      end else begin
         mid_x = x_ext + crm_pkg::DEC_BITS'(1);
         if (dec_neg) begin
            mid_y = y_ext;
            mid_d = dec_ff + (mid_x << 1) + crm_pkg::MID_INC;
         end else begin
            mid_y = y_ext - crm_pkg::DEC_BITS'(1);
            mid_d = dec_ff + ((mid_x - mid_y) << 1) + crm_pkg::MID_INC;
         end
      end
      mid_fin = $signed(mid_x) > $signed(mid_y);

      two_r      = crm_pkg::SX_BITS'({r_ff, 1'b0});
      col_over   = sx_ff > two_r;
      col_next_x = sx_ff + crm_pkg::SX_BITS'(1);
      col_fin    = col_next_x > two_r;
      if (sx_ff <= crm_pkg::SX_BITS'(r_ff)) begin
         col_off = crm_pkg::RADIUS_BITS'(crm_pkg::SX_BITS'(r_ff) - sx_ff);
      end else begin
         col_off = crm_pkg::RADIUS_BITS'(sx_ff - crm_pkg::SX_BITS'(r_ff));
      end
      col_base = cx_pix - crm_pkg::PIX_BITS'(r_ff) + crm_pkg::PIX_BITS'(sx_ff);

      push     = 1'b0;
      push_job = '{kind: crm_pkg::JOB_OCTANT, x_base: cx_pix, y_base: cy_pix,
                   a: x_ext[crm_pkg::PIX_BITS-1:0], b: y_ext[crm_pkg::PIX_BITS-1:0],
                   done: bres_fin};
      if (stepping && (mode_ff == crm_pkg::MODE_BRESENHAM)) begin
         push = 1'b1;
      end else if (stepping && (mode_ff == crm_pkg::MODE_MIDPOINT)) begin
         push       = 1'b1;
         push_job.a = mid_x[crm_pkg::PIX_BITS-1:0];
         push_job.b = mid_y[crm_pkg::PIX_BITS-1:0];
         push_job.done = mid_fin;
      end else if ((state_ff == F_ROOT) && !sq_busy && !queue_full) begin
         push     = 1'b1;
         push_job = '{kind: crm_pkg::JOB_COLUMN, x_base: col_ff, y_base: cy_pix,
                      a: '0, b: crm_pkg::PIX_BITS'(sq_root), done: fin_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         mode_ff  <= crm_pkg::MODE_RESET;
         cx_ff    <= '0;
         cy_ff    <= '0;
         r_ff     <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         dec_ff   <= '0;
         first_ff <= 1'b0;
         fin_ff   <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         unique case (state_ff)
            F_IDLE: begin
               if (accept && (req.command == crm_pkg::CMD_START)) begin
                  cx_ff    <= req.center_x;
                  cy_ff    <= req.center_y;
                  r_ff     <= req.radius;
                  sx_ff    <= '0;
                  sy_ff    <= (mode_ff == crm_pkg::MODE_COLUMN) ? '0
                              : crm_pkg::SY_BITS'(req.radius);
                  first_ff <= (mode_ff == crm_pkg::MODE_MIDPOINT);
                  fin_ff   <= (mode_ff != crm_pkg::MODE_COLUMN)
                              && (mode_ff != crm_pkg::MODE_BRESENHAM)
                              && (mode_ff != crm_pkg::MODE_MIDPOINT);
                  unique case (mode_ff)
                     crm_pkg::MODE_BRESENHAM: begin
                        dec_ff <= crm_pkg::BRES_INIT
                                  - crm_pkg::DEC_BITS'({req.radius, 1'b0});
                     end
                     crm_pkg::MODE_MIDPOINT: begin
                        dec_ff <= crm_pkg::MID_INIT - crm_pkg::DEC_BITS'(req.radius);
                     end
                     default: begin
                        dec_ff <= '0;
                     end
                  endcase
               end else if (stepping) begin
                  unique case (mode_ff)
                     crm_pkg::MODE_COLUMN: begin
                        if (col_over) begin
                           fin_ff <= 1'b1;
                        end else begin
                           off_ff   <= col_off;
                           col_ff   <= col_base;
                           sx_ff    <= col_next_x;
                           fin_ff   <= col_fin;
                           state_ff <= F_MUL;
                        end
                     end
                     crm_pkg::MODE_BRESENHAM: begin
                        sx_ff  <= bres_x[crm_pkg::SX_BITS-1:0];
                        sy_ff  <= bres_y[crm_pkg::SY_BITS-1:0];
                        dec_ff <= bres_d;
                        fin_ff <= bres_fin;
                     end
                     crm_pkg::MODE_MIDPOINT: begin
                        sx_ff    <= mid_x[crm_pkg::SX_BITS-1:0];
                        sy_ff    <= mid_y[crm_pkg::SY_BITS-1:0];
                        dec_ff   <= mid_d;
                        fin_ff   <= mid_fin;
                        first_ff <= 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            F_MUL: begin
               rr_ff    <= crm_pkg::SQ_BITS'(r_ff) * crm_pkg::SQ_BITS'(r_ff);
               oo_ff    <= crm_pkg::SQ_BITS'(off_ff) * crm_pkg::SQ_BITS'(off_ff);
               state_ff <= F_START;
            end
            F_START: begin
               state_ff <= F_ROOT;
            end
            F_ROOT: begin
               if (!sq_busy && !queue_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

[design/crm_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Two-entry first-in first-out buffer between the step engine and the emitter.
// ----------------------------------------------------------------------------
module crm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  crm_pkg::job_type push_job,
   input  logic             pop,
   output crm_pkg::job_type pop_job,
   output logic             full,
   output logic             empty
);

   crm_pkg::job_type                    mem_ff [crm_pkg::QUEUE_DEPTH];
   logic [crm_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff;
   logic [crm_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff;
   logic [crm_pkg::QUEUE_PTR_BITS:0]    count_ff;

   always_comb begin
      full    = count_ff == (crm_pkg::QUEUE_PTR_BITS+1)'(crm_pkg::QUEUE_DEPTH);
      empty   = count_ff == '0;
      pop_job = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + crm_pkg::QUEUE_PTR_BITS'(1);
         end
         if (pop && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + crm_pkg::QUEUE_PTR_BITS'(1);
         end
         priority if ((push && !full) && !(pop && !empty)) begin
            count_ff <= count_ff + (crm_pkg::QUEUE_PTR_BITS+1)'(1);
         end else if (!(push && !full) && (pop && !empty)) begin
            count_ff <= count_ff - (crm_pkg::QUEUE_PTR_BITS+1)'(1);
         end else begin
            count_ff <= count_ff;
         end
      end
   end

endmodule

[design/crm_back.sv]
// ----------------------------------------------------------------------------
// Pixel emitter
// Takes one job from the queue and sends its mirrored pixels, one per cycle
// while the pixel channel is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module crm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  crm_pkg::job_type pop_job,
   output logic             pop,
   crm_rsp_if.source        rsp
);

   crm_pkg::job_type                 job_ff;
   logic                             have_ff;
   logic [crm_pkg::SLOT_BITS-1:0]    slot_ff;
   logic                             valid_ff;
   logic [crm_pkg::PIX_BITS-1:0]     px_ff;
   logic [crm_pkg::PIX_BITS-1:0]     py_ff;
   logic                             last_ff;
   logic                             done_ff;

   logic                             out_free;
   logic                             load;
   logic [crm_pkg::SLOT_BITS-1:0]    slot;
   logic                             is_last;
   logic [crm_pkg::PIX_BITS-1:0]     px;
   logic [crm_pkg::PIX_BITS-1:0]     py;

   always_comb begin
      out_free = !valid_ff || rsp.ready;
      load     = have_ff && out_free;
      pop      = !have_ff && !queue_empty;

      if (job_ff.kind == crm_pkg::JOB_COLUMN) begin
         slot    = {1'b0, slot_ff[0], 1'b0};
         is_last = slot_ff == crm_pkg::LAST_COLUMN_SLOT;
      end else begin
         slot    = slot_ff;
         is_last = slot_ff == crm_pkg::LAST_OCTANT_SLOT;
      end

      unique case (slot)
         3'd0: begin px = job_ff.x_base + job_ff.a; py = job_ff.y_base + job_ff.b; end
         3'd1: begin px = job_ff.x_base + job_ff.b; py = job_ff.y_base + job_ff.a; end
         3'd2: begin px = job_ff.x_base + job_ff.a; py = job_ff.y_base - job_ff.b; end
         3'd3: begin px = job_ff.x_base - job_ff.b; py = job_ff.y_base + job_ff.a; end
         3'd4: begin px = job_ff.x_base - job_ff.a; py = job_ff.y_base + job_ff.b; end
         3'd5: begin px = job_ff.x_base + job_ff.b; py = job_ff.y_base - job_ff.a; end
         3'd6: begin px = job_ff.x_base - job_ff.a; py = job_ff.y_base - job_ff.b; end
         default: begin px = job_ff.x_base - job_ff.b; py = job_ff.y_base - job_ff.a; end
      endcase

      rsp.valid        = valid_ff;
      rsp.pixel_x      = $signed(px_ff);
      rsp.pixel_y      = $signed(py_ff);
      rsp.last_of_step = last_ff;
      rsp.curve_done   = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff  <= 1'b0;
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         if (pop) begin
            job_ff  <= pop_job;
            have_ff <= 1'b1;
            slot_ff <= '0;
         end
         if (load) begin
            px_ff    <= px;
            py_ff    <= py;
            last_ff  <= is_last;
            done_ff  <= job_ff.done;
            valid_ff <= 1'b1;
            slot_ff  <= slot_ff + crm_pkg::SLOT_BITS'(1);
            if (is_last) begin
               have_ff <= 1'b0;
            end
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

[design/circle_rasterizer_multi_mode.sv]
// ----------------------------------------------------------------------------
// Multi-mode circle rasterizer
// Generates circle pixels by column scan with square root, Bresenham or
// midpoint stepping, one scheme iteration per step transaction.
//
//   Channel   Direction  Carries
//   req_chan  in         command, center_x, center_y, radius
//   rsp_chan  out        pixel_x, pixel_y, last_of_step, curve_done
//   csr_*     in         algorithm_mode, written when csr_write_enable is high
//
// A start transaction produces nothing.
// An octant step produces eight pixels, on consecutive cycles while the output
// is not stalled, once its job is taken from the queue; a column step passes
// through the multiply stage and the iterative square root unit first.
// Reset is synchronous and returns the mode to Bresenham with no circle active.
// Output stalls fill the two-entry job queue, after which req_chan.ready drops.
// ----------------------------------------------------------------------------
module circle_rasterizer_multi_mode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [crm_pkg::MODE_BITS-1:0]  csr_write_data,
   crm_req_if.sink                        req_chan,
   crm_rsp_if.source                      rsp_chan
);

   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   crm_pkg::job_type push_job;
   crm_pkg::job_type pop_job;

   crm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   crm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   crm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule

[design/crm_checker.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer port checker
// Checks pixel channel behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module crm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [crm_pkg::PIX_BITS-1:0] rsp_pixel_x,
   input logic [crm_pkg::PIX_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_last,
   input logic                         rsp_done
);

   // A stalled pixel transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_last) && $stable(rsp_done))
      else $error("pixel transaction changed while stalled");

   // Reset leaves no pixel pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid after reset");

   // Pixels of one step follow each other without gaps and share curve_done.
   a_step_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid
         && (rsp_done == $past(rsp_done)))
      else $error("step pixels broken up or curve_done changed within a step");

endmodule

bind circle_rasterizer_multi_mode crm_checker u_crm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_pixel_x (rsp_chan.pixel_x),
   .rsp_pixel_y (rsp_chan.pixel_y),
   .rsp_last    (rsp_chan.last_of_step),
   .rsp_done    (rsp_chan.curve_done)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the multi-mode circle rasterizer
// Drives start and step transactions through all four mode settings and
// predicts every pixel of every step. Each accepted pixel is checked in order
// against the prediction. Idle and stall patterns vary by phase, and one
// long output hold-off makes the block fill up and stall its command channel.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [crm_pkg::MODE_BITS-1:0] MODE_UNDEFINED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [crm_pkg::PIX_BITS-1:0] x;
      logic [crm_pkg::PIX_BITS-1:0] y;
      logic                         last;
      logic                         done;
   } pixel_rec_type;

   class circle_scoreboard;
      logic [crm_pkg::MODE_BITS-1:0]       mode;
      logic [crm_pkg::COORD_BITS-1:0]      ctr_x;
      logic [crm_pkg::COORD_BITS-1:0]      ctr_y;
      logic [crm_pkg::RADIUS_BITS-1:0]     rad;
      logic [crm_pkg::SX_BITS-1:0]         oct_x;
      logic [crm_pkg::SY_BITS-1:0]         oct_y;
      logic signed [crm_pkg::DEC_BITS-1:0] decision;
      bit                                  first_pending;
      bit                                  finished;
      pixel_rec_type                       expected_pixels[$];
      pixel_rec_type                       burst[$];
      int                                  mismatches;
      int                                  pixels_checked;
      int                                  starts;
      int                                  live_items;
      int                                  steps_by_mode[4];

      function new();
         mode = crm_pkg::MODE_RESET;
         ctr_x = '0;
         ctr_y = '0;
         rad = '0;
         oct_x = '0;
         oct_y = '0;
         decision = '0;
         first_pending = 1'b0;
         finished = 1'b1;
      endfunction

      function void set_mode(logic [crm_pkg::MODE_BITS-1:0] m);
         mode = m;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 30) begin
            $display("[%0t] mismatch: %s", $time, msg);
         end
      endfunction

      function void add_pixel(int px, int py);
         pixel_rec_type p;
         p.x = crm_pkg::PIX_BITS'(px);
         p.y = crm_pkg::PIX_BITS'(py);
         p.last = 1'b0;
         p.done = 1'b0;
         burst.push_back(p);
      endfunction

      function void add_octants(int x, int y);
         int cx;
         int cy;
         cx = int'(ctr_x);
         cy = int'(ctr_y);
         add_pixel(cx + x, cy + y);
         add_pixel(cx + y, cy + x);
         add_pixel(cx + x, cy - y);
         add_pixel(cx - y, cy + x);
         add_pixel(cx - x, cy + y);
         add_pixel(cx + y, cy - x);
         add_pixel(cx - x, cy - y);
         add_pixel(cx - y, cy - x);
      endfunction

      function int unsigned floor_sqrt(int unsigned n);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 15; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
               root = trial;
            end
         end
         return root;
      endfunction

      function void note_command(logic cmd, logic [crm_pkg::COORD_BITS-1:0] cx_in,
                                 logic [crm_pkg::COORD_BITS-1:0] cy_in,
                                 logic [crm_pkg::RADIUS_BITS-1:0] r_in);
         int rr;
         int x;
         int y;
         int d;
         int off;
         int root;
         int col;
         live_items++;
         if (cmd == crm_pkg::CMD_START) begin
            starts++;
            ctr_x = cx_in;
            ctr_y = cy_in;
            rad = r_in;
            rr = int'(r_in);
            oct_x = '0;
            oct_y = (mode == crm_pkg::MODE_COLUMN) ? '0 : crm_pkg::SY_BITS'(r_in);
            first_pending = (mode == crm_pkg::MODE_MIDPOINT);
            finished = (mode == MODE_UNDEFINED);
            if (mode == crm_pkg::MODE_BRESENHAM) begin
               decision = crm_pkg::DEC_BITS'(int'(crm_pkg::BRES_INIT) - 2 * rr);
            end else if (mode == crm_pkg::MODE_MIDPOINT) begin
               decision = crm_pkg::DEC_BITS'(int'(crm_pkg::MID_INIT) - rr);
            end else begin
               decision = '0;
            end
            return;
         end
         if (finished || mode == MODE_UNDEFINED) begin
            return;
         end
         rr = int'(rad);
         x = int'(oct_x);
         y = int'(oct_y);
         d = int'(decision);
         burst.delete();
         if (mode == crm_pkg::MODE_COLUMN) begin
            if (x > 2 * rr) begin
               finished = 1'b1;
               return;
            end
            off = rr - x;
            root = int'(floor_sqrt(rr * rr - off * off));
            col = int'(ctr_x) - rr + x;
            add_pixel(col, int'(ctr_y) + root);
            add_pixel(col, int'(ctr_y) - root);
            x++;
            if (x > 2 * rr) begin
               finished = 1'b1;
            end
         end else if (mode == crm_pkg::MODE_BRESENHAM) begin
            add_octants(x, y);
            if (d < 0) begin
               d += 4 * x + int'(crm_pkg::BRES_INC_AXIAL);
            end else begin
               d += 4 * (x - y) + int'(crm_pkg::BRES_INC_DIAG);
               y--;
            end
            x++;
            if (x > y) begin
               finished = 1'b1;
            end
         end else begin
            if (first_pending) begin
               first_pending = 1'b0;
            end else begin
               x++;
               if (d < 0) begin
                  d += 2 * x + int'(crm_pkg::MID_INC);
               end else begin
                  y--;
                  d += 2 * (x - y) + int'(crm_pkg::MID_INC);
               end
            end
            add_octants(x, y);
            if (x > y) begin
               finished = 1'b1;
            end
         end
         oct_x = crm_pkg::SX_BITS'(x);
         oct_y = crm_pkg::SY_BITS'(y);
         decision = crm_pkg::DEC_BITS'(d);
         steps_by_mode[mode]++;
         burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) begin
            burst[i].done = finished;
            expected_pixels.push_back(burst[i]);
         end
      endfunction

      function void check_pixel(logic [crm_pkg::PIX_BITS-1:0] px,
                                logic [crm_pkg::PIX_BITS-1:0] py,
                                logic last, logic done);
         pixel_rec_type want;
         if (expected_pixels.size() == 0) begin
            report($sformatf("pixel (%0d,%0d) with nothing expected", $signed(px), $signed(py)));
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (px !== want.x) begin
            report($sformatf("pixel_x %0d, expected %0d", $signed(px), $signed(want.x)));
         end
         if (py !== want.y) begin
            report($sformatf("pixel_y %0d, expected %0d", $signed(py), $signed(want.y)));
         end
         if (last !== want.last) begin
            report($sformatf("last_of_step %b, expected %b", last, want.last));
         end
         if (done !== want.done) begin
            report($sformatf("curve_done %b, expected %b", done, want.done));
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_write_enable;
   logic [crm_pkg::MODE_BITS-1:0]  csr_write_data;
   int                             send_idle_pct;
   int                             recv_stall_pct;
   int                             hold_left;
   int                             cycle_count;
   int                             modes_written;
   circle_scoreboard               sb;

   crm_req_if req_chan ();
   crm_rsp_if rsp_chan ();

   circle_rasterizer_multi_mode dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("** circle_rasterizer_multi_mode: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_command(req_chan.command, req_chan.center_x, req_chan.center_y,
                            req_chan.radius);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_pixel(rsp_chan.pixel_x, rsp_chan.pixel_y, rsp_chan.last_of_step,
                           rsp_chan.curve_done);
         end
      end
   end

   task automatic send_command(input logic cmd,
                               input logic [crm_pkg::COORD_BITS-1:0] cx,
                               input logic [crm_pkg::COORD_BITS-1:0] cy,
                               input logic [crm_pkg::RADIUS_BITS-1:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.center_x <= cx;
      req_chan.center_y <= cy;
      req_chan.radius <= r;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic start_circle(input logic [crm_pkg::COORD_BITS-1:0] cx,
                               input logic [crm_pkg::COORD_BITS-1:0] cy,
                               input logic [crm_pkg::RADIUS_BITS-1:0] r);
      send_command(crm_pkg::CMD_START, cx, cy, r);
   endtask

   task automatic step_circle();
      send_command(crm_pkg::CMD_STEP, crm_pkg::COORD_BITS'($urandom),
                   crm_pkg::COORD_BITS'($urandom), crm_pkg::RADIUS_BITS'($urandom));
   endtask

   task automatic settle_pipeline();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [crm_pkg::MODE_BITS-1:0] m);
      settle_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_mode(m);
      modes_written++;
   endtask

   function automatic logic [crm_pkg::RADIUS_BITS-1:0] pick_radius();
      int p;
      p = $urandom_range(99);
      if (p < 70) begin
         return crm_pkg::RADIUS_BITS'($urandom_range(12));
      end else if (p < 95) begin
         return crm_pkg::RADIUS_BITS'($urandom_range(200, 13));
      end
      return crm_pkg::RADIUS_BITS'($urandom_range(2047, 201));
   endfunction

   task automatic random_circle();
      logic [crm_pkg::RADIUS_BITS-1:0] r;
      int steps;
      r = pick_radius();
      start_circle(crm_pkg::COORD_BITS'($urandom), crm_pkg::COORD_BITS'($urandom), r);
      steps = (sb.mode == crm_pkg::MODE_COLUMN) ? 2 * int'(r) + 1
              : (int'(r) * 3) / 4 + 3;
      if (steps > 24) begin
         steps = 24;
      end
      steps += $urandom_range(2);
      repeat (steps) step_circle();
   endtask

   task automatic random_phase(input logic [crm_pkg::MODE_BITS-1:0] m, input int idle_pct,
                               input int stall_pct, input int quota);
      int goal;
      write_mode(m);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      goal = sb.live_items + quota;
      while (sb.live_items < goal) begin
         if ($urandom_range(99) < 85) begin
            random_circle();
         end else begin
            send_command(1'($urandom), crm_pkg::COORD_BITS'($urandom),
                         crm_pkg::COORD_BITS'($urandom), crm_pkg::RADIUS_BITS'($urandom));
         end
      end
   endtask

   task automatic directed_cases();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      step_circle();
      start_circle(12'd0, 12'd0, 11'd0);
      step_circle();
      step_circle();
      write_mode(crm_pkg::MODE_MIDPOINT);
      start_circle(12'd4095, 12'd4095, 11'd0);
      repeat (3) step_circle();
      write_mode(crm_pkg::MODE_COLUMN);
      start_circle(12'd4095, 12'd0, 11'd0);
      repeat (2) step_circle();
      start_circle(12'd0, 12'd4095, 11'd2047);
      repeat (2) step_circle();
      write_mode(MODE_UNDEFINED);
      step_circle();
      start_circle(12'd2048, 12'd2048, 11'd5);
      step_circle();
      write_mode(crm_pkg::MODE_BRESENHAM);
      step_circle();
      start_circle(12'h555, 12'hAAA, 11'h555);
      step_circle();
      write_mode(crm_pkg::MODE_COLUMN);
      step_circle();
      write_mode(crm_pkg::MODE_MIDPOINT);
      step_circle();
      write_mode(crm_pkg::MODE_COLUMN);
      start_circle(12'hAAA, 12'h555, 11'd3);
      repeat (3) step_circle();
      write_mode(crm_pkg::MODE_BRESENHAM);
      repeat (2) step_circle();
   endtask

   task automatic output_hold_off();
      write_mode(crm_pkg::MODE_BRESENHAM);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 400;
      start_circle(12'd2000, 12'd2000, 11'd2047);
      repeat (30) step_circle();
   endtask

   initial begin
      logic [crm_pkg::MODE_BITS-1:0] phase_modes[9];
      int idle_table[4];
      int stall_table[4];
      sb = new();
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = crm_pkg::MODE_RESET;
      req_chan.valid = 1'b0;
      req_chan.command = crm_pkg::CMD_STEP;
      req_chan.center_x = '0;
      req_chan.center_y = '0;
      req_chan.radius = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      cycle_count = 0;
      modes_written = 0;
      phase_modes = '{crm_pkg::MODE_BRESENHAM, crm_pkg::MODE_COLUMN,
                      crm_pkg::MODE_MIDPOINT, crm_pkg::MODE_BRESENHAM,
                      crm_pkg::MODE_MIDPOINT, crm_pkg::MODE_COLUMN, MODE_UNDEFINED,
                      crm_pkg::MODE_MIDPOINT, crm_pkg::MODE_BRESENHAM};
      idle_table = '{0, 70, 0, 8};
      stall_table = '{0, 0, 70, 8};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_cases();
      foreach (phase_modes[i]) begin
         random_phase(phase_modes[i], idle_table[i % 4], stall_table[i % 4],
                      (phase_modes[i] == MODE_UNDEFINED) ? 15 : 45);
      end
      output_hold_off();
      settle_pipeline();

      $display("Ran %0d commands: %0d starts and %0d drawing steps (column %0d, %s %0d, %s %0d).",
               sb.live_items, sb.starts,
               sb.steps_by_mode[crm_pkg::MODE_COLUMN]
               + sb.steps_by_mode[crm_pkg::MODE_BRESENHAM]
               + sb.steps_by_mode[crm_pkg::MODE_MIDPOINT],
               sb.steps_by_mode[crm_pkg::MODE_COLUMN],
               "Bresenham", sb.steps_by_mode[crm_pkg::MODE_BRESENHAM],
               "midpoint", sb.steps_by_mode[crm_pkg::MODE_MIDPOINT]);
      $display("Checked %0d pixels across %0d mode writes; %0d mismatches.",
               sb.pixels_checked, modes_written, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("** circle_rasterizer_multi_mode: PASSED **");
      end else begin
         $display("** circle_rasterizer_multi_mode: FAILED **");
      end
      $finish;
   end
endmodule
